// ===== sv/uncompressed_audio_frame_packer_core_defines.svh =====
// Assertion macros shared by the verification files of the frame packer.
`ifndef UNCOMPRESSED_AUDIO_FRAME_PACKER_CORE_DEFINES_SVH
`define UNCOMPRESSED_AUDIO_FRAME_PACKER_CORE_DEFINES_SVH

// Property checked on every rising edge while reset is released.
`define UAFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define UAFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/uafp_pkg.sv =====
package uafp_pkg;

  // Field and frame constants.
  localparam int unsigned SAMPLE_W          = 16;
  localparam int unsigned FRAME_LEN_W       = 13;
  localparam logic [12:0] MAX_FRAME_SAMPLES = 13'd4096;
  localparam logic [12:0] STD_FRAME_LEN     = 13'd4096;
  localparam logic [22:0] HDR_BASE          = 23'h100001;
  localparam logic [22:0] HDR_HAS_SIZE      = 23'h000008;

  // Bit lengths pushed by one item.
  localparam logic [6:0] LEN_SLOT      = 7'd32;
  localparam logic [6:0] LEN_HDR_SLOT  = 7'd55;
  localparam logic [6:0] LEN_FULL_SLOT = 7'd87;

  // Job word: up to seven leftover bits plus 87 new bits, left aligned.
  localparam int unsigned JOB_BITS = 96;
  localparam logic [6:0]  JOB_BITS_C = 7'd96;

  // Input action codes.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_FILL   = 1'b1;

  // Register index codes (byte address bit 2).
  localparam logic REG_MONO_MODE     = 1'b0;
  localparam logic REG_FRAME_SAMPLES = 1'b1;

  // One packed item, ready to be sent out byte by byte.
  typedef struct packed {
    logic [JOB_BITS-1:0] data;
    logic [3:0]          nbytes;
    logic                last;
    logic                empty;
  } job_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic not_empty;
  } qstat_t;

endpackage

// ===== sv/uafp_front.sv =====
module uafp_front
  import uafp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       mono_mode,
  input  logic [FRAME_LEN_W-1:0]     frame_samples,
  input  logic                       accept,
  input  logic                       action,
  input  logic signed [SAMPLE_W-1:0] sample_left,
  input  logic signed [SAMPLE_W-1:0] sample_right,
  output job_t                       job
);

  logic [6:0]  res_r, res_nxt;
  logic [2:0]  rc_r, rc_nxt;
  logic [12:0] slot_r, slot_nxt;
  logic        hdr_done_r, hdr_done_nxt;
  logic        real_r, real_nxt;

  logic [12:0] eff_len;
  logic        has_size;
  logic [22:0] hdr;
  logic [15:0] left_v, right_v;
  logic [31:0] smp;
  logic [6:0]  push_len;
  logic [95:0] payload;
  logic [95:0] acc;
  logic [6:0]  total;
  logic [2:0]  rem;
  logic [6:0]  rem_mask;
  logic [12:0] slot_inc;
  logic        frame_end;

  // Clamp the frame length to the legal range.
  always_comb begin
    if (frame_samples == '0) begin
      eff_len = 13'd1;
    end else if (frame_samples > MAX_FRAME_SAMPLES) begin
      eff_len = MAX_FRAME_SAMPLES;
    end else begin
      eff_len = frame_samples;
    end
  end

  assign has_size = (eff_len != STD_FRAME_LEN);
  assign hdr      = has_size ? (HDR_BASE | HDR_HAS_SIZE) : HDR_BASE;

  // Sample word: mono copies left, zero fill clears both.
  always_comb begin
    left_v  = sample_left;
    right_v = mono_mode ? sample_left : sample_right;
    if (action == ACT_FILL) begin
      left_v  = '0;
      right_v = '0;
    end
  end
  assign smp = {left_v, right_v};

  // Bits this item pushes, right aligned.
  always_comb begin
    if (hdr_done_r) begin
      push_len = LEN_SLOT;
      payload  = {64'd0, smp};
    end else if (has_size) begin
      push_len = LEN_FULL_SLOT;
      payload  = {9'd0, hdr, 19'd0, eff_len, smp};
    end else begin
      push_len = LEN_HDR_SLOT;
      payload  = {41'd0, hdr, smp};
    end
  end

  // Leftover bits in front of the new ones, then left align the lot.
  assign acc      = ({89'd0, res_r} << push_len) | payload;
  assign total    = {4'd0, rc_r} + push_len;
  assign rem      = total[2:0];
  assign rem_mask = ~(7'h7f << rem);
  assign slot_inc = slot_r + 13'd1;
  assign frame_end = (slot_inc >= eff_len);

  always_comb begin
    job.data   = acc << (JOB_BITS_C - total);
    job.nbytes = total[6:3] + {3'd0, (frame_end && (rem != 3'd0))};
    job.last   = frame_end;
    job.empty  = !(real_r || (action == ACT_SAMPLE));
  end

  // Frame state for the next item.
  always_comb begin
    res_nxt      = res_r;
    rc_nxt       = rc_r;
    slot_nxt     = slot_r;
    hdr_done_nxt = hdr_done_r;
    real_nxt     = real_r;
    if (accept) begin
      if (frame_end) begin
        res_nxt      = '0;
        rc_nxt       = '0;
        slot_nxt     = '0;
        hdr_done_nxt = 1'b0;
        real_nxt     = 1'b0;
      end else begin
        res_nxt      = acc[6:0] & rem_mask;
        rc_nxt       = rem;
        slot_nxt     = slot_inc;
        hdr_done_nxt = 1'b1;
        real_nxt     = real_r || (action == ACT_SAMPLE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r      <= '0;
      rc_r       <= '0;
      slot_r     <= '0;
      hdr_done_r <= 1'b0;
      real_r     <= 1'b0;
    end else begin
      res_r      <= res_nxt;
      rc_r       <= rc_nxt;
      slot_r     <= slot_nxt;
      hdr_done_r <= hdr_done_nxt;
      real_r     <= real_nxt;
    end
  end

endmodule

// ===== sv/uafp_queue.sv =====
module uafp_queue
  import uafp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  job_t   push_job,
  input  logic   pop,
  output job_t   pop_job,
  output qstat_t stat
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.full      = (cnt_r == 2'd2);
  assign stat.not_empty = (cnt_r != 2'd0);
  assign pop_job        = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== sv/uafp_back.sv =====
module uafp_back
  import uafp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  qstat_t     stat,
  input  job_t       job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_byte,
  output logic       frame_empty
);

  logic                cur_valid_r, cur_valid_nxt;
  logic [JOB_BITS-1:0] data_r;
  logic [3:0]          left_r;
  logic                last_r;
  logic                empty_r;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          byte_r;
  logic                lastb_r;
  logic                fempty_r;

  logic out_free;
  logic adv;
  logic final_beat;
  logic load;

  assign out_free   = !out_valid_r || !out_stall;
  assign adv        = cur_valid_r && out_free;
  assign final_beat = (left_r == 4'd1);
  assign load       = stat.not_empty && (!cur_valid_r || (adv && final_beat));
  assign pop        = load;

  // Job and output register occupancy.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
    end else if (adv && final_beat) begin
      cur_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Current job: load a new one or shift out the top byte.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r  <= job.data;
      left_r  <= job.nbytes;
      last_r  <= job.last;
      empty_r <= job.empty;
    end else if (adv) begin
      data_r <= data_r << 8;
      left_r <= left_r - 4'd1;
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (adv) begin
      byte_r   <= data_r[JOB_BITS-1 -: 8];
      lastb_r  <= final_beat && last_r;
      fempty_r <= final_beat && last_r && empty_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = byte_r;
  assign last_byte   = lastb_r;
  assign frame_empty = fempty_r;

endmodule

// ===== sv/uncompressed_audio_frame_packer_core.sv =====
// Path: an accepted beat passes the queue, the job register and the output beat register.
// Throughput: one output byte per cycle while out_stall is low. A later slot gives 4 bytes,
// 5 when it flushes the last byte; the first slot 6 to 11 (header, size word, flush byte).
// The byte-wide output stage sets the rate; a two-entry queue lets input beats run ahead.
// Reset (synchronous, rst_n low) clears the frame state, the queue and the output,
// and sets mono_mode to 0 and frame_samples to 4096.
module uncompressed_audio_frame_packer_core
  import uafp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic signed [SAMPLE_W-1:0] in_sample_left,
  input  logic signed [SAMPLE_W-1:0] in_sample_right,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_out_byte,
  output logic                       out_last_byte,
  output logic                       out_frame_empty,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic                   mono_r, mono_nxt;
  logic [FRAME_LEN_W-1:0] fs_r, fs_nxt;
  logic                   cfg_wr;
  logic                   in_accept;
  job_t                   front_job;
  job_t                   back_job;
  qstat_t                 qstat;
  logic                   q_pop;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    mono_nxt = mono_r;
    fs_nxt   = fs_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_MONO_MODE:     mono_nxt = pwdata[0];
        REG_FRAME_SAMPLES: fs_nxt   = pwdata[FRAME_LEN_W-1:0];
        default:           mono_nxt = mono_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MONO_MODE:     prdata = {31'd0, mono_r};
      REG_FRAME_SAMPLES: prdata = {19'd0, fs_r};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r <= 1'b0;
      fs_r   <= STD_FRAME_LEN;
    end else begin
      mono_r <= mono_nxt;
      fs_r   <= fs_nxt;
    end
  end

  // Input side takes a beat whenever the queue has room.
  assign in_stall  = qstat.full;
  assign in_accept = in_valid && !qstat.full;

  uafp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .mono_mode     (mono_r),
    .frame_samples (fs_r),
    .accept        (in_accept),
    .action        (in_action),
    .sample_left   (in_sample_left),
    .sample_right  (in_sample_right),
    .job           (front_job)
  );

  uafp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_job (front_job),
    .pop      (q_pop),
    .pop_job  (back_job),
    .stat     (qstat)
  );

  uafp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .stat        (qstat),
    .job         (back_job),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_out_byte),
    .last_byte   (out_last_byte),
    .frame_empty (out_frame_empty)
  );

endmodule

// ===== sv/uafp_checker.sv =====
`include "uncompressed_audio_frame_packer_core_defines.svh"

module uafp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_out_byte,
  input logic        out_last_byte,
  input logic        out_frame_empty
);

  // A stalled output beat keeps its value.
  `UAFP_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(out_out_byte) &&
      $stable(out_last_byte) && $stable(out_frame_empty),
    "stalled output beat changed")

  // The empty flag only rides on the last byte of a frame.
  `UAFP_ASSERT(a_empty_on_last, out_valid && out_frame_empty |-> out_last_byte,
    "frame_empty without last_byte")

  // Reset leaves the output channel idle.
  `UAFP_ASSERT_ALWAYS(a_rst_out_idle, !rst_n |=> !out_valid, "output valid right after reset")

  // Reset leaves the queue empty, so the input side is open.
  `UAFP_ASSERT_ALWAYS(a_rst_in_open, !rst_n |=> !in_stall, "input stalled right after reset")

endmodule

bind uncompressed_audio_frame_packer_core uafp_checker u_uafp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_out_byte    (out_out_byte),
  .out_last_byte   (out_last_byte),
  .out_frame_empty (out_frame_empty)
);
